// ----- rtl/core/ncs_pkg.sv -----
// Types, constants, fixed-point helpers and the microprogram of the spline core.
package ncs_pkg;

	typedef logic signed [47:0] q48_t;

	typedef struct packed {
		logic clip;
		q48_t val;
	} q48_res_t;

	typedef struct packed {
		logic        sat;
		logic [31:0] val;
	} q32_res_t;

	// Result status codes
	localparam logic [2:0] ST_EVAL      = 3'd0;
	localparam logic [2:0] ST_FIT_OK    = 3'd1;
	localparam logic [2:0] ST_TOO_FEW   = 3'd2;
	localparam logic [2:0] ST_TOO_MANY  = 3'd3;
	localparam logic [2:0] ST_BAD_SPACE = 3'd4;
	localparam logic [2:0] ST_NOT_FIT   = 3'd5;

	// Item function codes
	localparam logic FN_LOAD = 1'b0;
	localparam logic FN_EVAL = 1'b1;

	// Micro-op codes
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_END = 3'd4;

	// Operand register codes
	localparam logic [4:0] R_XP = 5'd0;
	localparam logic [4:0] R_XC = 5'd1;
	localparam logic [4:0] R_XN = 5'd2;
	localparam logic [4:0] R_YP = 5'd3;
	localparam logic [4:0] R_YC = 5'd4;
	localparam logic [4:0] R_YN = 5'd5;
	localparam logic [4:0] R_RP = 5'd6;
	localparam logic [4:0] R_MP = 5'd7;
	localparam logic [4:0] R_MN = 5'd8;
	localparam logic [4:0] R_CB = 5'd9;
	localparam logic [4:0] R_CC = 5'd10;
	localparam logic [4:0] R_CD = 5'd11;
	localparam logic [4:0] R_QX = 5'd12;
	localparam logic [4:0] R_T0 = 5'd13;
	localparam logic [4:0] R_T1 = 5'd14;
	localparam logic [4:0] R_T2 = 5'd15;
	localparam logic [4:0] R_T3 = 5'd16;
	localparam logic [4:0] R_T4 = 5'd17;
	localparam logic [4:0] R_T5 = 5'd18;
	localparam logic [4:0] R_K1 = 5'd19;
	localparam logic [4:0] R_K2 = 5'd20;
	localparam logic [4:0] R_K3 = 5'd21;
	localparam logic [4:0] R_K6 = 5'd22;
	localparam logic [4:0] R_KH = 5'd23;

	typedef struct packed {
		logic [2:0] op;
		logic [4:0] dst;
		logic [4:0] sa;
		logic [4:0] sb;
	} uop_t;

	localparam int NUM_UOPS = 54;
	localparam logic [5:0] PC_FWD  = 6'd0;
	localparam logic [5:0] PC_BACK = 6'd19;
	localparam logic [5:0] PC_COEF = 6'd22;
	localparam logic [5:0] PC_QRY  = 6'd35;

	localparam uop_t UPROG [NUM_UOPS] = '{
		// forward sweep, interior knot
		'{OP_SUB, R_T0, R_XN, R_XP},  // span
		'{OP_SUB, R_T1, R_YN, R_YC},
		'{OP_SUB, R_T2, R_XN, R_XC},
		'{OP_DIV, R_T1, R_T1, R_T2},  // right slope
		'{OP_SUB, R_T2, R_YC, R_YP},
		'{OP_SUB, R_T3, R_XC, R_XP},
		'{OP_DIV, R_T2, R_T2, R_T3},  // left slope
		'{OP_SUB, R_T1, R_T1, R_T2},
		'{OP_DIV, R_T1, R_T1, R_T0},
		'{OP_MUL, R_T1, R_T1, R_K6},  // d
		'{OP_DIV, R_T3, R_T3, R_T0},  // mu
		'{OP_SUB, R_T2, R_K1, R_T3},  // lambda
		'{OP_MUL, R_T4, R_T3, R_RP},
		'{OP_SUB, R_T4, R_K2, R_T4},  // den
		'{OP_DIV, R_RP, R_T2, R_T4},
		'{OP_MUL, R_T5, R_T3, R_MP},
		'{OP_SUB, R_T5, R_T1, R_T5},
		'{OP_DIV, R_MP, R_T5, R_T4},
		'{OP_END, R_T0, R_T0, R_T0},
		// back substitution
		'{OP_MUL, R_T0, R_RP, R_MN},
		'{OP_SUB, R_MP, R_MP, R_T0},
		'{OP_END, R_T0, R_T0, R_T0},
		// segment coefficients
		'{OP_SUB, R_T0, R_XN, R_XC},  // h
		'{OP_SUB, R_T1, R_YN, R_YC},
		'{OP_DIV, R_T1, R_T1, R_T0},
		'{OP_MUL, R_T2, R_MP, R_K2},
		'{OP_ADD, R_T2, R_T2, R_MN},  // mix
		'{OP_DIV, R_T3, R_T0, R_K6},
		'{OP_MUL, R_T3, R_T3, R_T2},
		'{OP_SUB, R_CB, R_T1, R_T3},
		'{OP_MUL, R_CC, R_MP, R_KH},  // halving
		'{OP_SUB, R_T4, R_MN, R_MP},
		'{OP_MUL, R_T5, R_T0, R_K6},
		'{OP_DIV, R_CD, R_T4, R_T5},
		'{OP_END, R_T0, R_T0, R_T0},
		// evaluation
		'{OP_SUB, R_T0, R_QX, R_XC},  // t
		'{OP_MUL, R_T1, R_T0, R_T0},
		'{OP_MUL, R_T2, R_T1, R_T0},
		'{OP_MUL, R_T3, R_CB, R_T0},
		'{OP_ADD, R_T3, R_YC, R_T3},
		'{OP_MUL, R_T4, R_CC, R_T1},
		'{OP_ADD, R_T3, R_T3, R_T4},
		'{OP_MUL, R_T4, R_CD, R_T2},
		'{OP_ADD, R_T3, R_T3, R_T4},  // value
		'{OP_MUL, R_T4, R_CC, R_K2},
		'{OP_MUL, R_T5, R_T4, R_T0},
		'{OP_ADD, R_T5, R_CB, R_T5},
		'{OP_MUL, R_T2, R_CD, R_K3},
		'{OP_MUL, R_T2, R_T2, R_T1},
		'{OP_ADD, R_T5, R_T5, R_T2},  // slope
		'{OP_MUL, R_T2, R_CD, R_K6},
		'{OP_MUL, R_T2, R_T2, R_T0},
		'{OP_ADD, R_T4, R_T4, R_T2},  // curvature
		'{OP_END, R_T0, R_T0, R_T0}
	};

	function automatic q48_t sx32(input logic [31:0] v);
		return q48_t'($signed(v));
	endfunction

	function automatic logic [47:0] qmag(input q48_t a);
		return a[47] ? 48'(-a) : 48'(a);
	endfunction

	function automatic q48_res_t qaddsub(input q48_t a, input q48_t b, input logic sub);
		logic signed [48:0] s;
		q48_res_t r;
		s = sub ? ({a[47], a} - {b[47], b}) : ({a[47], a} + {b[47], b});
		r.clip = s[48] != s[47];
		r.val  = r.clip ? (s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) : s[47:0];
		return r;
	endfunction

	function automatic q48_res_t qpack(input logic neg, input logic ovf, input logic [47:0] mag);
		logic [47:0] lim;
		logic [47:0] m;
		q48_res_t r;
		lim = neg ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		r.clip = ovf || (mag > lim);
		m = r.clip ? lim : mag;
		r.val = neg ? q48_t'(-m) : q48_t'(m);
		return r;
	endfunction

	function automatic q32_res_t sat32(input q48_t v);
		q32_res_t r;
		if (v > q48_t'(32'sh7FFF_FFFF)) begin
			r.sat = 1'b1;
			r.val = 32'h7FFF_FFFF;
		end else if (v < q48_t'(-48'sh8000_0000)) begin
			r.sat = 1'b1;
			r.val = 32'h8000_0000;
		end else begin
			r.sat = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/ncs_in_if.sv -----
// Input channel: knot loads and evaluation queries.
interface ncs_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] x_coord;
	logic [31:0] y_coord;
	logic        last_knot;

	modport source (output valid, func, x_coord, y_coord, last_knot, input ready);
	modport sink (input valid, func, x_coord, y_coord, last_knot, output ready);
endinterface

// ----- rtl/core/ncs_out_if.sv -----
// Output channel: fit status and evaluation results.
interface ncs_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [5:0]  segment;
	logic [31:0] value;
	logic [31:0] slope;
	logic [31:0] curvature;
	logic        saturated;

	modport source (output valid, status, segment, value, slope, curvature, saturated,
		input ready);
	modport sink (input valid, status, segment, value, slope, curvature, saturated,
		output ready);
endinterface

// ----- rtl/core/natural_cubic_spline_fit_eval_core.sv -----
// Natural cubic spline core: knot store, fit sequencer and evaluator.
// Knot loads are taken one per cycle while idle. Query: a binary search over knot_x, then
// 11 multiplies on the shared multiplier and 7 adds or subtracts.
// Fit: 6 divides per interior knot (forward sweep) and 3 per segment, on the serial divider.
// Ready only in idle; a result waits in the output register while new knots are taken.
// arst_n clears control, count and fit flag; the knot and coefficient RAMs are not cleared.
module natural_cubic_spline_fit_eval_core #(
	parameter int MAX_POINTS = 64,
	parameter int FRAC_BITS  = 16
) (
	input logic clk,
	input logic arst_n,
	ncs_in_if.sink    item,
	ncs_out_if.source result
);
	import ncs_pkg::*;

	localparam int AW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 2);
	localparam int NW  = 48 + FRAC_BITS;        // dividend width after scaling
	localparam int DCW = $clog2(NW + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);
	localparam logic [DCW-1:0] DLAST = DCW'(NW);

	localparam q48_t K_ONE   = q48_t'(64'd1 << FRAC_BITS);
	localparam q48_t K_TWO   = q48_t'(64'd2 << FRAC_BITS);
	localparam q48_t K_THREE = q48_t'(64'd3 << FRAC_BITS);
	localparam q48_t K_SIX   = q48_t'(64'd6 << FRAC_BITS);
	localparam q48_t K_HALF  = q48_t'(64'd1 << (FRAC_BITS - 1));

	// sequencer states
	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_CHK_RD  = 5'd1;
	localparam logic [4:0] S_CHK_CMP = 5'd2;
	localparam logic [4:0] S_FW_INIT = 5'd3;
	localparam logic [4:0] S_LD_RD   = 5'd4;
	localparam logic [4:0] S_LD_SH   = 5'd5;
	localparam logic [4:0] S_FW_NEXT = 5'd6;
	localparam logic [4:0] S_FW_WR   = 5'd7;
	localparam logic [4:0] S_BK_RD   = 5'd8;
	localparam logic [4:0] S_BK_LD   = 5'd9;
	localparam logic [4:0] S_BK_WR   = 5'd10;
	localparam logic [4:0] S_CF_INIT = 5'd11;
	localparam logic [4:0] S_CF_NEXT = 5'd12;
	localparam logic [4:0] S_CF_WR   = 5'd13;
	localparam logic [4:0] S_QS_CHK  = 5'd14;
	localparam logic [4:0] S_QS_RD   = 5'd15;
	localparam logic [4:0] S_QS_CMP  = 5'd16;
	localparam logic [4:0] S_QV_RD   = 5'd17;
	localparam logic [4:0] S_QV_LD   = 5'd18;
	localparam logic [4:0] S_EXEC    = 5'd19;
	localparam logic [4:0] S_MUL     = 5'd20;
	localparam logic [4:0] S_DIV     = 5'd21;
	localparam logic [4:0] S_DONE    = 5'd22;

	logic [4:0]    state_q, ret_q;
	logic [CW-1:0] cnt_q, i_q, ldi_q, lo_q, hi_q, mid_q, kq_q;
	logic          fitted_q, shm_q, clip_q;
	logic [5:0]    pc_q;
	logic [2:0]    fin_status_q;

	// operand registers
	q48_t rx_xp_q, rx_xc_q, rx_xn_q, rx_yp_q, rx_yc_q, rx_yn_q;
	q48_t rx_rp_q, rx_mp_q, rx_mn_q, rx_cb_q, rx_cc_q, rx_cd_q, rx_qx_q;
	q48_t rx_t0_q, rx_t1_q, rx_t2_q, rx_t3_q, rx_t4_q, rx_t5_q;

	// shared multiplier (four 24x24 partial products)
	logic [47:0] ma_q, mb_q, pp_q;
	logic [95:0] acc_q;
	logic [1:0]  psel_q;
	logic [2:0]  mcnt_q;
	logic        mneg_q;

	// shared restoring divider, one quotient bit per cycle
	logic [NW-1:0]  num_q, quo_q;
	logic [47:0]    den_q, rem_q;
	logic [DCW-1:0] dcnt_q;
	logic           dneg_q, dzero_q;

	// output register
	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [5:0]  out_seg_q;
	logic [31:0] out_value_q, out_slope_q, out_curv_q;
	logic        out_sat_q;

	// memories
	logic [31:0] knot_x [MAX_POINTS];
	logic [31:0] knot_y [MAX_POINTS];
	q48_t        moment [MAX_POINTS];
	q48_t        sweep_ratio [MAX_POINTS];
	q48_t        coef_b [MAX_POINTS];
	q48_t        coef_c [MAX_POINTS];
	q48_t        coef_d [MAX_POINTS];
	logic [31:0] kx_rd_q, ky_rd_q;
	q48_t        mo_rd_q, ra_rd_q, cb_rd_q, cc_rd_q, cd_rd_q;

	logic [AW-1:0] rd_addr, wr_addr;
	logic          kn_we, mo_we, ra_we, cf_we;
	q48_t          mo_wd;

	logic          in_xfer, out_xfer, out_load;
	logic [CW-1:0] eff_cnt, new_cnt, j_m1, n_m2;
	uop_t          uop;
	q48_t          opa, opb;
	q48_res_t      as_res, mul_res, div_res, alu_res;
	logic          alu_we;
	logic [95:0]   mul_sh, pp_ext;
	logic [47:0]   a_part24, b_part24;
	logic [48:0]   rem_sh;
	logic          rem_ge;
	q32_res_t      v32, s32, c32;

	function automatic q48_t src_val(input logic [4:0] code);
		q48_t v;
		case (code)
			R_XP: v = rx_xp_q;
			R_XC: v = rx_xc_q;
			R_XN: v = rx_xn_q;
			R_YP: v = rx_yp_q;
			R_YC: v = rx_yc_q;
			R_YN: v = rx_yn_q;
			R_RP: v = rx_rp_q;
			R_MP: v = rx_mp_q;
			R_MN: v = rx_mn_q;
			R_CB: v = rx_cb_q;
			R_CC: v = rx_cc_q;
			R_CD: v = rx_cd_q;
			R_QX: v = rx_qx_q;
			R_T0: v = rx_t0_q;
			R_T1: v = rx_t1_q;
			R_T2: v = rx_t2_q;
			R_T3: v = rx_t3_q;
			R_T4: v = rx_t4_q;
			R_T5: v = rx_t5_q;
			R_K1: v = K_ONE;
			R_K2: v = K_TWO;
			R_K3: v = K_THREE;
			R_K6: v = K_SIX;
			R_KH: v = K_HALF;
			default: v = '0;
		endcase
		return v;
	endfunction

	assign item.ready     = (state_q == S_IDLE);
	assign in_xfer        = item.valid && item.ready;
	assign result.valid     = out_valid_q;
	assign result.status    = out_status_q;
	assign result.segment   = out_seg_q;
	assign result.value     = out_value_q;
	assign result.slope     = out_slope_q;
	assign result.curvature = out_curv_q;
	assign result.saturated = out_sat_q;
	assign out_xfer = out_valid_q && result.ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || result.ready);

	// a load after a good fit starts a fresh knot set
	assign eff_cnt = fitted_q ? '0 : cnt_q;
	assign new_cnt = (eff_cnt <= MAXC) ? eff_cnt + 1'b1 : eff_cnt;
	assign j_m1    = (lo_q == '0) ? '0 : lo_q - 1'b1;
	assign n_m2    = cnt_q - CW'(2);

	// ALU datapath
	assign uop    = UPROG[pc_q];
	assign opa    = src_val(uop.sa);
	assign opb    = src_val(uop.sb);
	assign as_res = qaddsub(opa, opb, uop.op == OP_SUB);

	assign mul_sh  = acc_q >> FRAC_BITS;
	assign mul_res = qpack(mneg_q, |mul_sh[95:48], mul_sh[47:0]);
	assign a_part24 = {24'd0, mcnt_q[1] ? ma_q[47:24] : ma_q[23:0]};
	assign b_part24 = {24'd0, mcnt_q[0] ? mb_q[47:24] : mb_q[23:0]};

	always_comb begin
		case (psel_q)
			2'd0:    pp_ext = {48'd0, pp_q};
			2'd3:    pp_ext = {pp_q, 48'd0};
			default: pp_ext = {24'd0, pp_q, 24'd0};
		endcase
	end

	assign rem_sh  = {rem_q, num_q[NW-1]};
	assign rem_ge  = rem_sh >= {1'b0, den_q};
	assign div_res = dzero_q ? q48_res_t'('0)
		: qpack(dneg_q, |quo_q[NW-1:48], quo_q[47:0]);

	always_comb begin
		alu_we  = 1'b0;
		alu_res = as_res;
		case (state_q)
			S_EXEC: alu_we = (uop.op == OP_ADD) || (uop.op == OP_SUB);
			S_MUL: begin
				alu_we  = (mcnt_q == 3'd5);
				alu_res = mul_res;
			end
			S_DIV: begin
				alu_we  = (dcnt_q == DLAST);
				alu_res = div_res;
			end
			default: alu_we = 1'b0;
		endcase
	end

	// output saturation to 32 bits
	assign v32 = sat32(rx_t3_q);
	assign s32 = sat32(rx_t5_q);
	assign c32 = sat32(rx_t4_q);

	// memory address and write control
	always_comb begin
		case (state_q)
			S_LD_RD: rd_addr = ldi_q[AW-1:0];
			S_QS_RD: rd_addr = mid_q[AW-1:0];
			S_QV_RD: rd_addr = kq_q[AW-1:0];
			default: rd_addr = i_q[AW-1:0];
		endcase
	end

	always_comb begin
		kn_we = in_xfer && (item.func == FN_LOAD) && (eff_cnt < MAXC);
		ra_we = (state_q == S_FW_WR);
		mo_we = (state_q == S_FW_WR) || (state_q == S_BK_WR);
		cf_we = (state_q == S_CF_WR);
		mo_wd = rx_mp_q;
		wr_addr = kn_we ? eff_cnt[AW-1:0] : i_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (kn_we) begin
			knot_x[wr_addr] <= item.x_coord;
			knot_y[wr_addr] <= item.y_coord;
		end
		kx_rd_q <= knot_x[rd_addr];
		ky_rd_q <= knot_y[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (mo_we) moment[wr_addr] <= mo_wd;
		if (ra_we) sweep_ratio[wr_addr] <= rx_rp_q;
		mo_rd_q <= moment[rd_addr];
		ra_rd_q <= sweep_ratio[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cf_we) begin
			coef_b[wr_addr] <= rx_cb_q;
			coef_c[wr_addr] <= rx_cc_q;
			coef_d[wr_addr] <= rx_cd_q;
		end
		cb_rd_q <= coef_b[rd_addr];
		cc_rd_q <= coef_c[rd_addr];
		cd_rd_q <= coef_d[rd_addr];
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			cnt_q <= '0;
			i_q <= '0;
			ldi_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			mid_q <= '0;
			kq_q <= '0;
			fitted_q <= 1'b0;
			shm_q <= 1'b0;
			clip_q <= 1'b0;
			pc_q <= '0;
			fin_status_q <= ST_EVAL;
			rx_xp_q <= '0; rx_xc_q <= '0; rx_xn_q <= '0;
			rx_yp_q <= '0; rx_yc_q <= '0; rx_yn_q <= '0;
			rx_rp_q <= '0; rx_mp_q <= '0; rx_mn_q <= '0;
			rx_cb_q <= '0; rx_cc_q <= '0; rx_cd_q <= '0; rx_qx_q <= '0;
			rx_t0_q <= '0; rx_t1_q <= '0; rx_t2_q <= '0;
			rx_t3_q <= '0; rx_t4_q <= '0; rx_t5_q <= '0;
			ma_q <= '0; mb_q <= '0; pp_q <= '0; acc_q <= '0;
			psel_q <= '0; mcnt_q <= '0; mneg_q <= 1'b0;
			num_q <= '0; quo_q <= '0; den_q <= '0; rem_q <= '0;
			dcnt_q <= '0; dneg_q <= 1'b0; dzero_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_status_q <= ST_EVAL;
			out_seg_q <= '0;
			out_value_q <= '0;
			out_slope_q <= '0;
			out_curv_q <= '0;
			out_sat_q <= 1'b0;
		end else begin
			if (out_xfer && !out_load) out_valid_q <= 1'b0;

			// ALU writeback
			if (alu_we) begin
				clip_q <= clip_q | alu_res.clip;
				case (uop.dst)
					R_RP: rx_rp_q <= alu_res.val;
					R_MP: rx_mp_q <= alu_res.val;
					R_CB: rx_cb_q <= alu_res.val;
					R_CC: rx_cc_q <= alu_res.val;
					R_CD: rx_cd_q <= alu_res.val;
					R_T0: rx_t0_q <= alu_res.val;
					R_T1: rx_t1_q <= alu_res.val;
					R_T2: rx_t2_q <= alu_res.val;
					R_T3: rx_t3_q <= alu_res.val;
					R_T4: rx_t4_q <= alu_res.val;
					R_T5: rx_t5_q <= alu_res.val;
					default: clip_q <= clip_q | alu_res.clip;
				endcase
				pc_q <= pc_q + 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (item.func == FN_LOAD) begin
							fitted_q <= 1'b0;
							cnt_q <= new_cnt;
							if (item.last_knot) begin
								if (new_cnt < CW'(2)) begin
									fin_status_q <= ST_TOO_FEW;
									cnt_q <= '0;
									state_q <= S_DONE;
								end else if (new_cnt > MAXC) begin
									fin_status_q <= ST_TOO_MANY;
									cnt_q <= '0;
									state_q <= S_DONE;
								end else begin
									i_q <= '0;
									state_q <= S_CHK_RD;
								end
							end
						end else if (!fitted_q) begin
							fin_status_q <= ST_NOT_FIT;
							state_q <= S_DONE;
						end else begin
							rx_qx_q <= sx32(item.x_coord);
							lo_q <= '0;
							hi_q <= cnt_q;
							state_q <= S_QS_CHK;
						end
					end
				end

				// x must strictly increase
				S_CHK_RD: state_q <= S_CHK_CMP;
				S_CHK_CMP: begin
					rx_xc_q <= sx32(kx_rd_q);
					if ((i_q != '0) && (sx32(kx_rd_q) <= rx_xc_q)) begin
						fin_status_q <= ST_BAD_SPACE;
						cnt_q <= '0;
						state_q <= S_DONE;
					end else if (i_q == cnt_q - 1'b1) begin
						state_q <= S_FW_INIT;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_CHK_RD;
					end
				end

				// forward sweep
				S_FW_INIT: begin
					rx_rp_q <= '0;
					rx_mp_q <= '0;
					i_q <= '0;
					ldi_q <= '0;
					shm_q <= 1'b0;
					state_q <= S_FW_WR;
				end
				S_FW_WR: begin
					i_q <= i_q + 1'b1;
					state_q <= S_FW_NEXT;
				end
				S_FW_NEXT: begin
					if (i_q == cnt_q) begin
						i_q <= n_m2;
						rx_mn_q <= '0;
						state_q <= S_BK_RD;
					end else if (i_q + 1'b1 < cnt_q) begin
						if (ldi_q != i_q + CW'(2)) begin
							ret_q <= S_FW_NEXT;
							state_q <= S_LD_RD;
						end else begin
							pc_q <= PC_FWD;
							ret_q <= S_FW_WR;
							state_q <= S_EXEC;
						end
					end else begin
						rx_rp_q <= '0;
						rx_mp_q <= '0;
						state_q <= S_FW_WR;
					end
				end

				// shift one knot into the window
				S_LD_RD: state_q <= S_LD_SH;
				S_LD_SH: begin
					rx_xp_q <= rx_xc_q;
					rx_xc_q <= rx_xn_q;
					rx_xn_q <= sx32(kx_rd_q);
					rx_yp_q <= rx_yc_q;
					rx_yc_q <= rx_yn_q;
					rx_yn_q <= sx32(ky_rd_q);
					if (shm_q) begin
						rx_mp_q <= rx_mn_q;
						rx_mn_q <= mo_rd_q;
					end
					ldi_q <= ldi_q + 1'b1;
					state_q <= ret_q;
				end

				// back substitution
				S_BK_RD: state_q <= S_BK_LD;
				S_BK_LD: begin
					rx_mp_q <= mo_rd_q;
					rx_rp_q <= ra_rd_q;
					pc_q <= PC_BACK;
					ret_q <= S_BK_WR;
					state_q <= S_EXEC;
				end
				S_BK_WR: begin
					rx_mn_q <= rx_mp_q;
					if (i_q == '0) begin
						state_q <= S_CF_INIT;
					end else begin
						i_q <= i_q - 1'b1;
						state_q <= S_BK_RD;
					end
				end

				// segment coefficients
				S_CF_INIT: begin
					i_q <= '0;
					ldi_q <= '0;
					shm_q <= 1'b1;
					state_q <= S_CF_NEXT;
				end
				S_CF_NEXT: begin
					if (i_q == cnt_q - 1'b1) begin
						fitted_q <= 1'b1;
						fin_status_q <= ST_FIT_OK;
						state_q <= S_DONE;
					end else if (ldi_q != i_q + CW'(2)) begin
						ret_q <= S_CF_NEXT;
						state_q <= S_LD_RD;
					end else begin
						pc_q <= PC_COEF;
						ret_q <= S_CF_WR;
						state_q <= S_EXEC;
					end
				end
				S_CF_WR: begin
					i_q <= i_q + 1'b1;
					state_q <= S_CF_NEXT;
				end

				// lower-bound search over knot_x
				S_QS_CHK: begin
					if (lo_q < hi_q) begin
						mid_q <= CW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
						state_q <= S_QS_RD;
					end else begin
						kq_q <= (j_m1 > n_m2) ? n_m2 : j_m1;
						state_q <= S_QV_RD;
					end
				end
				S_QS_RD: state_q <= S_QS_CMP;
				S_QS_CMP: begin
					if (sx32(kx_rd_q) < rx_qx_q) lo_q <= mid_q + 1'b1;
					else hi_q <= mid_q;
					state_q <= S_QS_CHK;
				end
				S_QV_RD: state_q <= S_QV_LD;
				S_QV_LD: begin
					rx_xc_q <= sx32(kx_rd_q);
					rx_yc_q <= sx32(ky_rd_q);
					rx_cb_q <= cb_rd_q;
					rx_cc_q <= cc_rd_q;
					rx_cd_q <= cd_rd_q;
					clip_q <= 1'b0;
					fin_status_q <= ST_EVAL;
					pc_q <= PC_QRY;
					ret_q <= S_DONE;
					state_q <= S_EXEC;
				end

				// micro-op issue
				S_EXEC: begin
					case (uop.op)
						OP_MUL: begin
							ma_q <= qmag(opa);
							mb_q <= qmag(opb);
							mneg_q <= opa[47] ^ opb[47];
							acc_q <= '0;
							mcnt_q <= '0;
							state_q <= S_MUL;
						end
						OP_DIV: begin
							num_q <= NW'(qmag(opa)) << FRAC_BITS;
							den_q <= qmag(opb);
							dneg_q <= opa[47] ^ opb[47];
							dzero_q <= (opa == '0);
							rem_q <= '0;
							quo_q <= '0;
							dcnt_q <= '0;
							state_q <= S_DIV;
						end
						OP_END: state_q <= ret_q;
						default: state_q <= S_EXEC;
					endcase
				end
				S_MUL: begin
					if (mcnt_q < 3'd4) begin
						pp_q <= 48'(a_part24[23:0] * b_part24[23:0]);
						psel_q <= mcnt_q[1:0];
					end
					if ((mcnt_q != 3'd0) && (mcnt_q < 3'd5)) acc_q <= acc_q + pp_ext;
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == 3'd5) state_q <= S_EXEC;
				end
				S_DIV: begin
					if (dcnt_q == DLAST) begin
						state_q <= S_EXEC;
					end else begin
						num_q <= num_q << 1;
						quo_q <= {quo_q[NW-2:0], rem_ge};
						rem_q <= rem_ge ? 48'(rem_sh - {1'b0, den_q}) : rem_sh[47:0];
						dcnt_q <= dcnt_q + 1'b1;
					end
				end

				S_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_status_q <= fin_status_q;
						if (fin_status_q == ST_EVAL) begin
							out_seg_q <= 6'(kq_q);
							out_value_q <= v32.val;
							out_slope_q <= s32.val;
							out_curv_q <= c32.val;
							out_sat_q <= clip_q | v32.sat | s32.sat | c32.sat;
						end else begin
							out_seg_q <= '0;
							out_value_q <= '0;
							out_slope_q <= '0;
							out_curv_q <= '0;
							out_sat_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
